// ===== rtl/server_selector_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Server selector table assertion macros
// Shared concurrent assertion forms for the server selector table modules.
// ----------------------------------------------------------------------------
`ifndef SERVER_SELECTOR_TABLE_CORE_ASSERT_SVH
`define SERVER_SELECTOR_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define SSEL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssel assertion failed");

// next-cycle implication
`define SSEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssel assertion failed");

`endif

// ===== rtl/ssel_pkg.sv =====
// ----------------------------------------------------------------------------
// Server selector table package
// Shared types, codes and fixed widths of the server selector table.
// ----------------------------------------------------------------------------
package ssel_pkg;

   // fixed field widths
   localparam int RND_W      = 16;
   localparam int CONN_W     = 16;
   localparam int REQ_SUM_W  = 36;
   localparam int CONN_SUM_W = 20;
   localparam int WEIGHT_MAX = 10;

   typedef enum logic [3:0] {
      ACT_ADD     = 4'd0,
      ACT_REMOVE  = 4'd1,
      ACT_SELECT  = 4'd2,
      ACT_SUCCESS = 4'd3,
      ACT_FAILURE = 4'd4,
      ACT_SET_HLT = 4'd5,
      ACT_GET_HLT = 4'd6,
      ACT_CHECK   = 4'd7,
      ACT_SET_CON = 4'd8,
      ACT_STATS   = 4'd9,
      ACT_RESET   = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2,
      STS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STRAT_RR = 2'd0,
      STRAT_LC = 2'd1,
      STRAT_WR = 2'd2,
      STRAT_UR = 2'd3
   } strategy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_PROC,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [3:0]        action;
      logic [3:0]        entry_id;
      logic [7:0]        weight;
      logic              health_bit;
      logic [CONN_W-1:0] connection_value;
      logic [RND_W-1:0]  random_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [3:0]            chosen_id;
      logic                  health_out;
      logic [REQ_SUM_W-1:0]  request_sum;
      logic [REQ_SUM_W-1:0]  failure_sum;
      logic [CONN_SUM_W-1:0] connection_sum;
      logic [3:0]            busiest_id;
      logic                  busiest_valid;
      logic [4:0]            entry_count;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic proc;
      logic div_start;
      logic div_take;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic quick;
      logic go_div;
      logic last;
      logic hit;
      logic div_after;
      logic weighted;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/ssel_if.sv =====
// ----------------------------------------------------------------------------
// Server selector table channel interfaces
// Request, response and control register write channels.
// ----------------------------------------------------------------------------
interface ssel_req_if import ssel_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [3:0]          action;
   logic [3:0]          entry_id;
   logic [7:0]          weight;
   logic                health_bit;
   logic [CONN_W-1:0]   connection_value;
   logic [RND_W-1:0]    random_value;

   modport source (output valid, action, entry_id, weight, health_bit,
                   connection_value, random_value, input ready);
   modport sink (input valid, action, entry_id, weight, health_bit,
                 connection_value, random_value, output ready);
endinterface

interface ssel_rsp_if import ssel_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [3:0]            chosen_id;
   logic                  health_out;
   logic [REQ_SUM_W-1:0]  request_sum;
   logic [REQ_SUM_W-1:0]  failure_sum;
   logic [CONN_SUM_W-1:0] connection_sum;
   logic [3:0]            busiest_id;
   logic                  busiest_valid;
   logic [4:0]            entry_count;

   modport source (output valid, status, chosen_id, health_out, request_sum,
                   failure_sum, connection_sum, busiest_id, busiest_valid,
                   entry_count, input ready);
   modport sink (input valid, status, chosen_id, health_out, request_sum,
                 failure_sum, connection_sum, busiest_id, busiest_valid,
                 entry_count, output ready);
endinterface

interface ssel_csr_if ();
   logic       valid;
   logic       ready;
   logic [1:0] strategy;

   modport source (output valid, strategy, input ready);
   modport sink (input valid, strategy, output ready);
endinterface

// ===== rtl/ssel_div.sv =====
// ----------------------------------------------------------------------------
// Server selector table remainder unit
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module ssel_div import ssel_pkg::*; #(
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RND_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVS_W-1:0] rem
);

   localparam int CNT_W = $clog2(RND_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   trial;

   // one shift and subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/ssel_ctrl.sv =====
// ----------------------------------------------------------------------------
// Server selector table controller
// Sequences one action: start, entry scan, remainder, result hand-off.
// ----------------------------------------------------------------------------
module ssel_ctrl import ssel_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  stat_type stat,
   output logic     req_ready,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            if (stat.quick) begin
               state_in = ST_FINISH;
            end else if (stat.go_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PROC;
         end
         ST_PROC: begin
            cmd.proc = 1'b1;
            if (stat.hit) begin
               state_in = ST_FINISH;
            end else if (stat.last) begin
               if (stat.div_after) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = stat.weighted ? ST_READ : ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ssel_dp.sv =====
// ----------------------------------------------------------------------------
// Server selector table datapath
// Entry memory, table registers, scan accumulators and result register.
// ----------------------------------------------------------------------------
`include "server_selector_table_core_assert.svh"

module ssel_dp import ssel_pkg::*; #(
   parameter int MAX_SERVERS  = 16,
   parameter int COUNTER_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_item_type req_item,
   input  logic         csr_valid,
   input  logic [1:0]   csr_strategy,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   output stat_type     stat
);

   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int IDX_W  = $clog2(MAX_SERVERS);
   localparam int DV_W   = $clog2(WEIGHT_MAX * MAX_SERVERS + 1);
   localparam int DV1_W  = DV_W + 1;
   localparam int FL20_W = COUNTER_BITS + 5;
   localparam int CB     = COUNTER_BITS;

   typedef struct packed {
      logic [3:0]        w;
      logic              h;
      logic [CONN_W-1:0] c;
      logic [CB-1:0]     rq;
      logic [CB-1:0]     fl;
   } entry_type;

   entry_type mem [MAX_SERVERS];
   entry_type rdata_ff;
   entry_type wd;
   logic             we;
   logic [IDX_W-1:0] wa, ra;

   // control registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rot_ff, rot_in;
   logic [1:0]       strat_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // item and scan registers
   logic [3:0]            act_ff, act_in;
   logic [3:0]            id_ff, id_in;
   logic [7:0]            wt_ff, wt_in;
   logic                  hb_ff, hb_in;
   logic [CONN_W-1:0]     conn_ff, conn_in;
   logic [RND_W-1:0]      rnd_ff, rnd_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  pass_ff, pass_in;
   logic [1:0]            status_ff, status_in;
   logic [3:0]            chosen_ff, chosen_in;
   logic                  hout_ff, hout_in;
   logic [REQ_SUM_W-1:0]  rsum_ff, rsum_in;
   logic [REQ_SUM_W-1:0]  fsum_ff, fsum_in;
   logic [CONN_SUM_W-1:0] csum_ff, csum_in;
   logic [CB-1:0]         bmax_ff, bmax_in;
   logic [3:0]            bid_ff, bid_in;
   logic                  bvalid_ff, bvalid_in;
   logic [CONN_W-1:0]     minc_ff, minc_in;
   logic [DV_W-1:0]       wsum_ff, wsum_in;
   logic [DV_W-1:0]       acc_ff, acc_in;
   logic [DV_W-1:0]       rem_ff, rem_in;
   rsp_item_type          out_ff, out_in;

   // derived terms
   logic             id_ok, empty, is_single;
   logic [IDX_W-1:0] id_idx, rr_sel, rr_next;
   logic [FL20_W-1:0] fl20;
   logic [DV_W-1:0]  div_dvs, div_rem;
   logic             div_done;

   assign id_idx    = IDX_W'(id_ff);
   assign id_ok     = 32'(id_ff) < 32'(count_ff);
   assign empty     = (count_ff == '0);
   assign is_single = (act_ff == ACT_SUCCESS) || (act_ff == ACT_FAILURE) ||
                      (act_ff == ACT_SET_HLT) || (act_ff == ACT_GET_HLT) ||
                      (act_ff == ACT_SET_CON);
   assign rr_sel    = (32'(rot_ff) >= 32'(count_ff)) ? '0 : rot_ff;
   assign rr_next   = (32'(rr_sel) + 1 >= 32'(count_ff)) ? '0 : rr_sel + IDX_W'(1);
   assign fl20      = (FL20_W'(rdata_ff.fl) << 4) + (FL20_W'(rdata_ff.fl) << 2);
   assign ra        = (act_ff == ACT_REMOVE) ? idx_ff + IDX_W'(1) : idx_ff;
   assign div_dvs   = (strat_ff == STRAT_UR) ? DV_W'(count_ff) : wsum_in;

   ssel_div #(.DVS_W(DV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rnd_ff),
      .divisor  (div_dvs),
      .done     (div_done),
      .rem      (div_rem)
   );

   // status toward the controller
   always_comb begin
      stat          = '0;
      stat.weighted = (strat_ff == STRAT_WR);
      stat.div_done = div_done;
      stat.out_free = !rsp_valid_ff || rsp_ready;
      stat.hit      = (act_ff == ACT_SELECT) && (strat_ff == STRAT_WR) && pass_ff &&
                      ({1'b0, rem_ff} < ({1'b0, acc_ff} + DV1_W'(rdata_ff.w)));
      stat.div_after = (act_ff == ACT_SELECT) && (strat_ff == STRAT_WR) && !pass_ff;
      if (act_ff == ACT_REMOVE) begin
         stat.last = 32'(idx_ff) + 2 >= 32'(count_ff);
      end else if (is_single) begin
         stat.last = 1'b1;
      end else begin
         stat.last = 32'(idx_ff) + 1 >= 32'(count_ff);
      end
      priority case (1'b1)
         act_ff == ACT_ADD:    stat.quick = 1'b1;
         act_ff == ACT_REMOVE: stat.quick = !id_ok || (32'(id_ff) + 1 == 32'(count_ff));
         act_ff == ACT_SELECT: begin
            stat.quick  = empty || (strat_ff == STRAT_RR);
            stat.go_div = !empty && (strat_ff == STRAT_UR);
         end
         is_single:            stat.quick = !id_ok;
         (act_ff == ACT_CHECK) || (act_ff == ACT_STATS) || (act_ff == ACT_RESET):
                               stat.quick = empty;
         default:              stat.quick = 1'b1;
      endcase
   end

   // next values of all registers and the memory write
   always_comb begin
      count_in     = count_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff;
      act_in    = act_ff;
      id_in     = id_ff;
      wt_in     = wt_ff;
      hb_in     = hb_ff;
      conn_in   = conn_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      pass_in   = pass_ff;
      status_in = status_ff;
      chosen_in = chosen_ff;
      hout_in   = hout_ff;
      rsum_in   = rsum_ff;
      fsum_in   = fsum_ff;
      csum_in   = csum_ff;
      bmax_in   = bmax_ff;
      bid_in    = bid_ff;
      bvalid_in = bvalid_ff;
      minc_in   = minc_ff;
      wsum_in   = wsum_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      out_in    = out_ff;
      we        = 1'b0;
      wa        = idx_ff;
      wd        = rdata_ff;

      // capture the accepted item
      if (cmd.load) begin
         act_in  = req_item.action;
         id_in   = req_item.entry_id;
         wt_in   = req_item.weight;
         hb_in   = req_item.health_bit;
         conn_in = req_item.connection_value;
         rnd_in  = req_item.random_value;
      end

      // checks and the actions completed in the start state
      if (cmd.start) begin
         idx_in    = ((act_ff == ACT_REMOVE) || is_single) ? id_idx : '0;
         pass_in   = 1'b0;
         status_in = STS_OK;
         chosen_in = '0;
         hout_in   = 1'b0;
         rsum_in   = '0;
         fsum_in   = '0;
         csum_in   = '0;
         bmax_in   = '0;
         bid_in    = '0;
         bvalid_in = 1'b0;
         wsum_in   = '0;
         acc_in    = '0;
         priority case (1'b1)
            act_ff == ACT_ADD: begin
               if (32'(count_ff) >= MAX_SERVERS) begin
                  status_in = STS_FULL;
               end else begin
                  we    = 1'b1;
                  wa    = IDX_W'(count_ff);
                  wd    = '0;
                  wd.w  = ((wt_ff >= 8'd1) && (wt_ff <= 8'(WEIGHT_MAX))) ? 4'(wt_ff) : 4'd1;
                  wd.h  = 1'b1;
                  chosen_in = 4'(count_ff);
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            act_ff == ACT_REMOVE: begin
               if (!id_ok) begin
                  status_in = STS_RANGE;
               end else if (32'(id_ff) + 1 == 32'(count_ff)) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            act_ff == ACT_SELECT: begin
               if (empty) begin
                  status_in = STS_EMPTY;
               end else if (strat_ff == STRAT_RR) begin
                  chosen_in = 4'(rr_sel);
                  rot_in    = rr_next;
               end
            end
            is_single: begin
               if (!id_ok) begin
                  status_in = STS_RANGE;
               end
            end
            default: begin
            end
         endcase
      end

      // one entry of a scan
      if (cmd.proc) begin
         idx_in = idx_ff + IDX_W'(1);
         unique case (act_ff)
            ACT_REMOVE: begin
               we = 1'b1;
               if (stat.last) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_SELECT: begin
               if (strat_ff == STRAT_LC) begin
                  if ((idx_ff == '0) || (rdata_ff.c < minc_ff)) begin
                     minc_in   = rdata_ff.c;
                     chosen_in = 4'(idx_ff);
                  end
               end else if (!pass_ff) begin
                  wsum_in = wsum_ff + DV_W'(rdata_ff.w);
               end else begin
                  acc_in = acc_ff + DV_W'(rdata_ff.w);
                  if (stat.hit) begin
                     chosen_in = 4'(idx_ff);
                  end
               end
            end
            ACT_SUCCESS: begin
               we    = 1'b1;
               wd.rq = (rdata_ff.rq == '1) ? rdata_ff.rq : rdata_ff.rq + CB'(1);
            end
            ACT_FAILURE: begin
               we    = 1'b1;
               wd.fl = (rdata_ff.fl == '1) ? rdata_ff.fl : rdata_ff.fl + CB'(1);
            end
            ACT_SET_HLT: begin
               we   = 1'b1;
               wd.h = hb_ff;
            end
            ACT_GET_HLT: begin
               hout_in = rdata_ff.h;
            end
            ACT_SET_CON: begin
               we   = 1'b1;
               wd.c = conn_ff;
            end
            ACT_CHECK: begin
               we   = 1'b1;
               wd.h = (rdata_ff.rq == '0) || (fl20 < FL20_W'(rdata_ff.rq));
            end
            ACT_STATS: begin
               rsum_in = rsum_ff + REQ_SUM_W'(rdata_ff.rq);
               fsum_in = fsum_ff + REQ_SUM_W'(rdata_ff.fl);
               csum_in = csum_ff + CONN_SUM_W'(rdata_ff.c);
               if (rdata_ff.rq > bmax_ff) begin
                  bmax_in   = rdata_ff.rq;
                  bid_in    = 4'(idx_ff);
                  bvalid_in = 1'b1;
               end
            end
            ACT_RESET: begin
               we    = 1'b1;
               wd.rq = '0;
               wd.fl = '0;
            end
            default: begin
            end
         endcase
      end

      // remainder back from the divider
      if (cmd.div_take) begin
         rem_in  = div_rem;
         idx_in  = '0;
         acc_in  = '0;
         pass_in = 1'b1;
         if (strat_ff == STRAT_UR) begin
            chosen_in = 4'(div_rem);
         end
      end

      // result register
      if (cmd.finish) begin
         rsp_valid_in         = 1'b1;
         out_in               = '0;
         out_in.status        = status_ff;
         out_in.chosen_id     = chosen_ff;
         out_in.health_out    = hout_ff;
         out_in.entry_count   = 5'(count_ff);
         if (act_ff == ACT_STATS) begin
            out_in.request_sum    = rsum_ff;
            out_in.failure_sum    = fsum_ff;
            out_in.connection_sum = csum_ff;
            out_in.busiest_id     = bid_ff;
            out_in.busiest_valid  = bvalid_ff;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rot_ff       <= '0;
         strat_ff     <= STRAT_RR;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            strat_ff <= csr_strategy;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      id_ff     <= id_in;
      wt_ff     <= wt_in;
      hb_ff     <= hb_in;
      conn_ff   <= conn_in;
      rnd_ff    <= rnd_in;
      idx_ff    <= idx_in;
      pass_ff   <= pass_in;
      status_ff <= status_in;
      chosen_ff <= chosen_in;
      hout_ff   <= hout_in;
      rsum_ff   <= rsum_in;
      fsum_ff   <= fsum_in;
      csum_ff   <= csum_in;
      bmax_ff   <= bmax_in;
      bid_ff    <= bid_in;
      bvalid_ff <= bvalid_in;
      minc_ff   <= minc_in;
      wsum_ff   <= wsum_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      out_ff    <= out_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = out_ff;

   `SSEL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= MAX_SERVERS)
   `SSEL_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)
   `SSEL_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)

endmodule

// ===== rtl/server_selector_table_core.sv =====
// ----------------------------------------------------------------------------
// Server selector table core
// Load-balancing table of servers with selection, records and statistics.
// ----------------------------------------------------------------------------
// One action at a time. Add, round-robin select and any action refused for a
// bad id, full or empty table go straight from the start state to the result. Actions
// on one entry visit only that entry; table scans (least connections, health check,
// stats, stats reset) and removes visit the entries one by one, since every
// entry goes through the single registered read port of the entry memory.
// Uniform random select adds a pass through the remainder unit; weighted random
// select scans the weights, runs the remainder unit, then scans again up to
// the chosen entry. A finished result waits in the output register while the
// next request is taken.
module server_selector_table_core import ssel_pkg::*; #(
   parameter int MAX_SERVERS  = 16,
   parameter int COUNTER_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   ssel_req_if.sink   req_bus,
   ssel_rsp_if.source rsp_bus,
   ssel_csr_if.sink   csr_bus
);

   cmd_type      cmd;
   stat_type     stat;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         rsp_valid;
   logic         req_ready;

   // pack the request payload
   assign req_item.action           = req_bus.action;
   assign req_item.entry_id         = req_bus.entry_id;
   assign req_item.weight           = req_bus.weight;
   assign req_item.health_bit       = req_bus.health_bit;
   assign req_item.connection_value = req_bus.connection_value;
   assign req_item.random_value     = req_bus.random_value;
   assign req_bus.ready             = req_ready;
   assign csr_bus.ready             = 1'b1;

   ssel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ssel_dp #(
      .MAX_SERVERS  (MAX_SERVERS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_item     (req_item),
      .csr_valid    (csr_bus.valid),
      .csr_strategy (csr_bus.strategy),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .stat         (stat)
   );

   // unpack the response payload
   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.status         = rsp_item.status;
   assign rsp_bus.chosen_id      = rsp_item.chosen_id;
   assign rsp_bus.health_out     = rsp_item.health_out;
   assign rsp_bus.request_sum    = rsp_item.request_sum;
   assign rsp_bus.failure_sum    = rsp_item.failure_sum;
   assign rsp_bus.connection_sum = rsp_item.connection_sum;
   assign rsp_bus.busiest_id     = rsp_item.busiest_id;
   assign rsp_bus.busiest_valid  = rsp_item.busiest_valid;
   assign rsp_bus.entry_count    = rsp_item.entry_count;

endmodule
